// ===== rtl/tvs_pkg.sv =====
// Shared types, constants and lerp helpers for the trilinear volume sampler.
// No dependencies.
package tvs_pkg;

  localparam int MAX_DIM_DEF = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int SIZE_W      = 6;
  localparam int VOX_W       = 5;
  localparam int DATA_W      = 16;
  localparam int COORD_W     = 8;   // holds an index for any grid up to 256 points
  localparam int Q_DEPTH     = 4;
  localparam int OUT_DEPTH   = 8;
  localparam int PROD_W      = DATA_W + 1 + SAMPLE_BITS + 1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  // decoded item between front and back
  typedef struct packed {
    logic                   op;
    logic                   wr_ok;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [COORD_W-1:0]     z;
    logic [SAMPLE_BITS-1:0] tx;
    logic [SAMPLE_BITS-1:0] ty;
    logic [SAMPLE_BITS-1:0] tz;
    logic [DATA_W-1:0]      value;
  } item_t;

  // a zero fraction ignores the upper end, which may lie past the grid
  function automatic logic signed [PROD_W-1:0] lerp_mul(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b,
      input logic [SAMPLE_BITS-1:0]   t);
    logic signed [DATA_W:0]        d;
    logic signed [SAMPLE_BITS:0]   ts;
    if (t == '0) return '0;
    d  = {b[DATA_W-1], b} - {a[DATA_W-1], a};
    ts = {1'b0, t};
    return PROD_W'(d * ts);
  endfunction

  // floor shift and add; the result always stays between the lerp ends
  function automatic logic signed [DATA_W-1:0] lerp_fin(
      input logic signed [DATA_W-1:0] a,
      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-SAMPLE_BITS-1:0] q;
    logic signed [PROD_W-SAMPLE_BITS-1:0] s;
    q = p[PROD_W-1:SAMPLE_BITS];
    s = (PROD_W-SAMPLE_BITS)'(a) + q;
    return s[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/tvs_front.sv =====
// Front end: takes input beats, maps sample points to base index and fraction,
// and queues decoded items for the back end. Depends on tvs_pkg.
module tvs_front import tvs_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_op,
  input  logic [VOX_W-1:0]         in_voxel_x,
  input  logic [VOX_W-1:0]         in_voxel_y,
  input  logic [VOX_W-1:0]         in_voxel_z,
  input  logic signed [DATA_W-1:0] in_voxel_value,
  input  logic signed [15:0]       in_point_x,
  input  logic signed [15:0]       in_point_y,
  input  logic signed [15:0]       in_point_z,
  input  logic [SIZE_W-1:0]        size_x,
  input  logic [SIZE_W-1:0]        size_y,
  input  logic [SIZE_W-1:0]        size_z,
  output logic                     q_valid,
  output item_t                    q_head,
  input  logic                     q_pop
);

  localparam int AW  = $clog2(MAX_DIM);
  localparam int NW  = AW + 1;
  localparam int GW  = SAMPLE_BITS + AW;
  localparam int QPW = $clog2(Q_DEPTH);

  function automatic logic [NW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return NW'(1);
    if (32'(s) > MAX_DIM) return NW'(MAX_DIM);
    return NW'(s);
  endfunction

  function automatic logic [GW-1:0] map_axis(input logic [15:0] p,
                                             input logic [SIZE_W-1:0] s);
    logic [SAMPLE_BITS-1:0] u;
    logic [NW-1:0]          n;
    logic [AW-1:0]          nm1;
    u   = SAMPLE_BITS'(p) ^ (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1));
    n   = eff_size(s);
    nm1 = AW'(n - NW'(1));
    return GW'(u) * GW'(nm1);
  endfunction

  item_t            q_mem [Q_DEPTH];
  logic [QPW-1:0]   wp_r, rp_r;
  logic [QPW:0]     cnt_r;
  logic             push;
  item_t            dec;
  logic [GW-1:0]    gx, gy, gz;

  assign in_full = (cnt_r == (QPW+1)'(Q_DEPTH));
  assign push    = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem[rp_r];

  always_comb begin
    gx = map_axis(in_point_x, size_x);
    gy = map_axis(in_point_y, size_y);
    gz = map_axis(in_point_z, size_z);
    dec       = '0;
    dec.op    = in_op;
    dec.value = in_voxel_value;
    if (in_op == OP_WRITE) begin
      dec.wr_ok = (32'(in_voxel_x) < MAX_DIM) && (32'(in_voxel_y) < MAX_DIM) &&
                  (32'(in_voxel_z) < MAX_DIM);
      dec.x = COORD_W'(in_voxel_x);
      dec.y = COORD_W'(in_voxel_y);
      dec.z = COORD_W'(in_voxel_z);
    end else begin
      dec.x  = COORD_W'(gx[SAMPLE_BITS +: AW]);
      dec.y  = COORD_W'(gy[SAMPLE_BITS +: AW]);
      dec.z  = COORD_W'(gz[SAMPLE_BITS +: AW]);
      dec.tx = gx[SAMPLE_BITS-1:0];
      dec.ty = gy[SAMPLE_BITS-1:0];
      dec.tz = gz[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPW'(1);
      if (q_pop) rp_r <= rp_r + QPW'(1);
      cnt_r <= cnt_r + (QPW+1)'(push) - (QPW+1)'(q_pop);
    end
  end

endmodule

// ===== rtl/tvs_bank.sv =====
// One parity bank of the voxel store: one write port, one registered read port.
// No dependencies.
module tvs_bank #(
  parameter int RW = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [3*RW-1:0]   waddr,
  input  logic [15:0]       wdata,
  input  logic [3*RW-1:0]   raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [2**(3*RW)];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tvs_back.sv =====
// Back end: eight parity banks, a four-stage lerp pipeline and the result queue.
// Depends on tvs_pkg and tvs_bank.
module tvs_back import tvs_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_t                    q_head,
  output logic                     q_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [DATA_W-1:0] out_density_out
);

  localparam int AW  = $clog2(MAX_DIM);
  localparam int RW  = (AW > 1) ? AW - 1 : 1;
  localparam int PW  = $clog2(OUT_DEPTH + 1);
  localparam int OPW = $clog2(OUT_DEPTH);

  logic [PW-1:0] pend_r;
  logic          issue_smp, take;
  logic [AW-1:0] hx, hy, hz;

  assign hx = q_head.x[AW-1:0];
  assign hy = q_head.y[AW-1:0];
  assign hz = q_head.z[AW-1:0];

  // samples need a reserved slot in the result queue; writes always go
  assign q_pop     = q_valid && (q_head.op == OP_WRITE || pend_r < PW'(OUT_DEPTH));
  assign issue_smp = q_pop && (q_head.op == OP_SAMPLE);
  assign take      = out_pop && !out_empty;

  // bank b holds voxels whose coordinate parities are {z,y,x} == b.
  // The upper neighbor is base+1 in the other parity bank; when it lies past
  // the grid the fraction is zero, so its value never counts.
  logic signed [DATA_W-1:0] bank_q [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [AW-1:0] xe, ye, ze;
    logic [RW-1:0] rx, ry, rz, wx, wy, wz;
    logic          we;
    assign xe = hx + AW'(hx[0] ^ b[0]);
    assign ye = hy + AW'(hy[0] ^ b[1]);
    assign ze = hz + AW'(hz[0] ^ b[2]);
    assign rx = RW'(xe >> 1);
    assign ry = RW'(ye >> 1);
    assign rz = RW'(ze >> 1);
    assign wx = RW'(hx >> 1);
    assign wy = RW'(hy >> 1);
    assign wz = RW'(hz >> 1);
    assign we = q_pop && (q_head.op == OP_WRITE) && q_head.wr_ok &&
                ({hz[0], hy[0], hx[0]} == 3'(b));
    tvs_bank #(.RW(RW)) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr ({wz, wy, wx}),
      .wdata (q_head.value),
      .raddr ({rz, ry, rx}),
      .rdata (bank_q[b])
    );
  end

  // stage 1: bank data arrives
  logic                   v1_r;
  logic [2:0]             par1_r;
  logic [SAMPLE_BITS-1:0] tx1_r, ty1_r, tz1_r;

  always_ff @(posedge clk) begin
    par1_r <= {hz[0], hy[0], hx[0]};
    tx1_r  <= q_head.tx;
    ty1_r  <= q_head.ty;
    tz1_r  <= q_head.tz;
  end

  // stage 2: x lerp products, index {k,j}
  logic                     v2_r;
  logic signed [DATA_W-1:0] a2_r [4];
  logic signed [PROD_W-1:0] p2_r [4];
  logic [SAMPLE_BITS-1:0]   ty2_r, tz2_r;

  always_ff @(posedge clk) begin
    for (int jk = 0; jk < 4; jk++) begin
      a2_r[jk] <= bank_q[{par1_r[2] ^ jk[1], par1_r[1] ^ jk[0], par1_r[0]}];
      p2_r[jk] <= lerp_mul(bank_q[{par1_r[2] ^ jk[1], par1_r[1] ^ jk[0], par1_r[0]}],
                           bank_q[{par1_r[2] ^ jk[1], par1_r[1] ^ jk[0], ~par1_r[0]}],
                           tx1_r);
    end
    ty2_r <= ty1_r;
    tz2_r <= tz1_r;
  end

  // stage 3: y lerp products
  logic                     v3_r;
  logic signed [DATA_W-1:0] c [4];
  logic signed [DATA_W-1:0] a3_r [2];
  logic signed [PROD_W-1:0] p3_r [2];
  logic [SAMPLE_BITS-1:0]   tz3_r;

  always_comb begin
    for (int i = 0; i < 4; i++) c[i] = lerp_fin(a2_r[i], p2_r[i]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      a3_r[k] <= c[2*k];
      p3_r[k] <= lerp_mul(c[2*k], c[2*k+1], ty2_r);
    end
    tz3_r <= tz2_r;
  end

  // stage 4: z lerp product
  logic                     v4_r;
  logic signed [DATA_W-1:0] r0, r1, a4_r, res;
  logic signed [PROD_W-1:0] p4_r;

  assign r0  = lerp_fin(a3_r[0], p3_r[0]);
  assign r1  = lerp_fin(a3_r[1], p3_r[1]);
  assign res = lerp_fin(a4_r, p4_r);

  always_ff @(posedge clk) begin
    a4_r <= r0;
    p4_r <= lerp_mul(r0, r1, tz3_r);
  end

  // result queue
  logic signed [DATA_W-1:0] omem [OUT_DEPTH];
  logic [OPW-1:0]           owp_r, orp_r;
  logic [PW-1:0]            ocnt_r;

  assign out_empty       = (ocnt_r == '0);
  assign out_density_out = omem[orp_r];

  always_ff @(posedge clk) begin
    if (v4_r) omem[owp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
      pend_r <= '0;
    end else begin
      v1_r   <= issue_smp;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      if (v4_r) owp_r <= owp_r + OPW'(1);
      if (take) orp_r <= orp_r + OPW'(1);
      ocnt_r <= ocnt_r + PW'(v4_r) - PW'(take);
      pend_r <= pend_r + PW'(issue_smp) - PW'(take);
    end
  end

endmodule

// ===== rtl/trilinear_volume_sampler.sv =====
// Trilinear volume sampler, top level: size registers, front end and back end.
// Throughput: one item per cycle; a stalled consumer backs up through the
// 8-entry result queue and the 4-entry item queue before full goes high.
// Reset clears queues, pipeline valids and sizes (32); voxel store is not cleared.
// Depends on tvs_pkg, tvs_front, tvs_back.
module trilinear_volume_sampler import tvs_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_op,
  input  logic [VOX_W-1:0]         in_voxel_x,
  input  logic [VOX_W-1:0]         in_voxel_y,
  input  logic [VOX_W-1:0]         in_voxel_z,
  input  logic signed [DATA_W-1:0] in_voxel_value,
  input  logic signed [15:0]       in_point_x,
  input  logic signed [15:0]       in_point_y,
  input  logic signed [15:0]       in_point_z,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [DATA_W-1:0] out_density_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data
);

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic              q_valid, q_pop;
  item_t             q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_W'(32);
      size_y_r <= SIZE_W'(32);
      size_z_r <= SIZE_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tvs_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_voxel_x     (in_voxel_x),
    .in_voxel_y     (in_voxel_y),
    .in_voxel_z     (in_voxel_z),
    .in_voxel_value (in_voxel_value),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .size_x         (size_x_r),
    .size_y         (size_y_r),
    .size_z         (size_z_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop)
  );

  tvs_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_density_out (out_density_out)
  );

endmodule

// ===== rtl/tvs_checker.sv =====
// Port-level checks for the trilinear volume sampler, bound to the top level.
// Depends on trilinear_volume_sampler.
module tvs_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic signed [15:0] out_density_out
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // once the item queue and pipeline have had time to drain, an idle empty
  // block stays empty
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
      (out_empty && !in_push) [*12] |=> out_empty)
    else $error("result appeared without a prior beat");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && !out_pop) |=> (!out_empty && $stable(out_density_out)))
    else $error("waiting result changed");

endmodule

bind trilinear_volume_sampler tvs_port_checker u_tvs_port_checker (.*);

// ===== dv/tvs_checker.sv =====
// Checker for the trilinear volume sampler: watches the input, config and result
// channels, keeps its own voxel grid and sizes, and predicts each density.
// Depends on tvs_pkg.
`timescale 1ns / 1ps
module tvs_checker import tvs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic                     in_full,
  input  logic                     in_op,
  input  logic [VOX_W-1:0]         in_voxel_x,
  input  logic [VOX_W-1:0]         in_voxel_y,
  input  logic [VOX_W-1:0]         in_voxel_z,
  input  logic signed [DATA_W-1:0] in_voxel_value,
  input  logic signed [15:0]       in_point_x,
  input  logic signed [15:0]       in_point_y,
  input  logic signed [15:0]       in_point_z,
  input  logic                     out_empty,
  input  logic                     out_pop,
  input  logic signed [DATA_W-1:0] out_density_out,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data,
  output int                       fail_count,
  output int                       pending
);

  logic signed [DATA_W-1:0] grid [0:32767];
  logic [SIZE_W-1:0]        dim_x, dim_y, dim_z;
  logic signed [DATA_W-1:0] density_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int eff_dim(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > 32) return 32;
    return int'(s);
  endfunction

  // maps a Q1.15 coordinate onto grid cells: base, upper neighbor, fraction
  function automatic void map_coord(input logic [15:0] p, input logic [SIZE_W-1:0] s,
                                    output int lo, output int hi, output longint t);
    longint u, g;
    int     n;
    n  = eff_dim(s);
    u  = longint'({~p[15], p[14:0]});
    g  = u * (n - 1);
    lo = int'(g >> 16);
    t  = g & 64'hFFFF;
    hi = (lo + 1 < n) ? lo + 1 : n - 1;
  endfunction

  function automatic longint lerp16(input longint a, input longint b, input longint t);
    longint prod;
    prod = (b - a) * t;
    return a + (prod >>> 16);
  endfunction

  function automatic longint voxel_at(input int x, input int y, input int z);
    return longint'(grid[x + y * 32 + z * 1024]);
  endfunction

  function automatic logic signed [DATA_W-1:0] density_at(input logic [15:0] px,
                                                          input logic [15:0] py,
                                                          input logic [15:0] pz);
    int     x0, x1, y0, y1, z0, z1;
    longint tx, ty, tz, c00, c10, c01, c11, r0, r1, r;
    map_coord(px, dim_x, x0, x1, tx);
    map_coord(py, dim_y, y0, y1, ty);
    map_coord(pz, dim_z, z0, z1, tz);
    c00 = lerp16(voxel_at(x0, y0, z0), voxel_at(x1, y0, z0), tx);
    c10 = lerp16(voxel_at(x0, y1, z0), voxel_at(x1, y1, z0), tx);
    c01 = lerp16(voxel_at(x0, y0, z1), voxel_at(x1, y0, z1), tx);
    c11 = lerp16(voxel_at(x0, y1, z1), voxel_at(x1, y1, z1), tx);
    r0  = lerp16(c00, c10, ty);
    r1  = lerp16(c01, c11, ty);
    r   = lerp16(r0, r1, tz);
    return r[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dim_x <= 6'd32;
      dim_y <= 6'd32;
      dim_z <= 6'd32;
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_X: dim_x <= cfg_data;
          REG_SIZE_Y: dim_y <= cfg_data;
          REG_SIZE_Z: dim_z <= cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (in_op == OP_WRITE)
          grid[in_voxel_x + in_voxel_y * 32 + in_voxel_z * 1024] = in_voxel_value;
        else
          density_q.push_back(density_at(in_point_x, in_point_y, in_point_z));
      end
      if (out_pop && !out_empty) begin
        if (density_q.size() == 0)
          report_mismatch("unexpected density beat", int'(out_density_out), 0);
        else if (out_density_out !== density_q[0]) begin
          report_mismatch("density_out", int'(out_density_out), int'(density_q[0]));
          void'(density_q.pop_front());
        end else
          void'(density_q.pop_front());
      end
      pending = density_q.size();
    end
  end

endmodule

// ===== dv/trilinear_volume_sampler_tb.sv =====
// Testbench top for the trilinear volume sampler: clock, reset, stimulus and verdict.
// Depends on tvs_pkg, trilinear_volume_sampler and tvs_checker.
`timescale 1ns / 1ps
module trilinear_volume_sampler_tb import tvs_pkg::*;;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic                     in_op = OP_WRITE;
  logic [VOX_W-1:0]         in_voxel_x = '0;
  logic [VOX_W-1:0]         in_voxel_y = '0;
  logic [VOX_W-1:0]         in_voxel_z = '0;
  logic signed [DATA_W-1:0] in_voxel_value = '0;
  logic signed [15:0]       in_point_x = '0;
  logic signed [15:0]       in_point_y = '0;
  logic signed [15:0]       in_point_z = '0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic signed [DATA_W-1:0] out_density_out;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index = '0;
  logic [SIZE_W-1:0]        cfg_data = '0;
  int                       fail_count;
  int                       pending;

  int  send_idle_pct = 0;
  int  pop_stall_pct = 0;
  int  box_x = 32, box_y = 32, box_z = 32;
  int  cycles = 0;
  bit  written [0:32767];

  always #2 clk = ~clk;

  trilinear_volume_sampler u_top (.*);

  tvs_checker u_chk (.*);

  always @(posedge clk) out_pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int eff_dim(input int s);
    if (s == 0) return 1;
    if (s > 32) return 32;
    return s;
  endfunction

  task automatic push_item(input logic op, input int vx, input int vy, input int vz,
                           input logic [15:0] val, input logic [15:0] px,
                           input logic [15:0] py, input logic [15:0] pz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_push        <= 1'b1;
    in_op          <= op;
    in_voxel_x     <= vx[VOX_W-1:0];
    in_voxel_y     <= vy[VOX_W-1:0];
    in_voxel_z     <= vz[VOX_W-1:0];
    in_voxel_value <= val;
    in_point_x     <= px;
    in_point_y     <= py;
    in_point_z     <= pz;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (op == OP_WRITE) written[vx + vy * 32 + vz * 1024] = 1'b1;
  endtask

  task automatic write_voxel(input int x, input int y, input int z, input logic [15:0] v);
    push_item(OP_WRITE, x, y, z, v, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic sample_point(input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] pz);
    push_item(OP_SAMPLE, $urandom_range(31), $urandom_range(31), $urandom_range(31),
              16'($urandom), px, py, pz);
  endtask

  // stop sending and let every expected beat drain, plus pipeline slack
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[SIZE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // set all sizes, then make sure every voxel a sample can touch holds data
  task automatic set_grid(input int sx, input int sy, input int sz, input bit extreme);
    drain();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    box_x = eff_dim(sx);
    box_y = eff_dim(sy);
    box_z = eff_dim(sz);
    for (int z = 0; z < box_z; z++)
      for (int y = 0; y < box_y; y++)
        for (int x = 0; x < box_x; x++)
          if (!written[x + y * 32 + z * 1024] || extreme)
            write_voxel(x, y, z, extreme ? ($urandom_range(1) ? 16'h7FFF : 16'h8000)
                                         : 16'($urandom));
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic directed_samples();
    sample_point(16'h8000, 16'h8000, 16'h8000);
    sample_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    sample_point(16'h0000, 16'hFFFF, 16'h7FFF);
    sample_point(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  int sx, sy, sz;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out-of-list index must be ignored
    write_reg(cfg_reg_t'(2'd3), 5);
    // size zero acts as one, size above 32 saturates
    set_grid(0, 1, 1, 1'b1);
    directed_samples();
    set_grid(63, 2, 1, 1'b1);
    directed_samples();
    set_grid(1, 32, 2, 1'b0);
    directed_samples();
    set_grid(2, 1, 32, 1'b0);
    directed_samples();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 76; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 76; end
        default: begin send_idle_pct = 26; pop_stall_pct = 26; end
      endcase
      sx = $urandom_range(1, 5);
      sy = $urandom_range(1, 5);
      sz = $urandom_range(1, 5);
      // a long axis keeps the other two thin so the fill stays short
      case ($urandom_range(5))
        0: begin sx = 32; sy = 1; sz = 1; end
        1: sy = 0;
        2: begin sz = $urandom_range(33, 63); sx = 1; sy = 1; end
        default: ;
      endcase
      set_grid(sx, sy, sz, 1'b0);
      for (int i = 0; i < 90; i++) begin
        if (ph == 2 && i == 50) drain();
        if ($urandom_range(99) < 30) begin
          if ($urandom_range(99) < 70)
            write_voxel($urandom_range(box_x - 1), $urandom_range(box_y - 1),
                        $urandom_range(box_z - 1), 16'($urandom));
          else
            write_voxel($urandom_range(31), $urandom_range(31), $urandom_range(31),
                        16'($urandom));
        end else
          sample_point(rand_coord(), rand_coord(), rand_coord());
      end
    end

    drain();
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tvs_pkg.sv
rtl/tvs_front.sv
rtl/tvs_bank.sv
rtl/tvs_back.sv
rtl/trilinear_volume_sampler.sv
rtl/tvs_checker.sv
dv/tvs_checker.sv
dv/trilinear_volume_sampler_tb.sv
